// ----- src/emt_pkg.sv -----
// ----------------------------------------------------------------------------
// emt_pkg
// shared types and constants of the edge mesh to triangles block
// ----------------------------------------------------------------------------
package emt_pkg;

   localparam int MaxVertices = 4096;
   localparam int MaxEdges    = 8192;
   localparam int MaxSurfaces = 4096;
   localparam int VaW = $clog2(MaxVertices);
   localparam int EaW = $clog2(MaxEdges);
   localparam int SaW = $clog2(MaxSurfaces);

   localparam logic [1:0] CMD_LOAD_VERTEX  = 2'd0;
   localparam logic [1:0] CMD_LOAD_EDGE    = 2'd1;
   localparam logic [1:0] CMD_LOAD_SURFACE = 2'd2;
   localparam logic [1:0] CMD_PROCESS      = 2'd3;

   localparam logic [2:0] CSR_VERTEX_TOTAL  = 3'd0;
   localparam logic [2:0] CSR_EDGE_TOTAL    = 3'd1;
   localparam logic [2:0] CSR_SURFACE_TOTAL = 3'd2;
   localparam logic [2:0] CSR_SCALE         = 3'd3;
   localparam logic [2:0] CSR_MIN_AREA      = 3'd4;

   localparam int QueueDepth = 2;

   typedef struct packed {
      logic [1:0]         command;
      logic [12:0]        index;
      logic signed [23:0] coord_x;
      logic signed [23:0] coord_y;
      logic signed [23:0] coord_z;
      logic [15:0]        start_vertex;
      logic [15:0]        end_vertex;
      logic [15:0]        left_surface;
      logic [15:0]        right_surface;
      logic [15:0]        first_edge;
   } cmd_type;

   typedef struct packed {
      logic [12:0] vertex_total;
      logic [13:0] edge_total;
      logic [12:0] surface_total;
      logic [9:0]  scale;
      logic [47:0] min_area_sq;
   } csr_type;

endpackage

// ----- src/emt_front.sv -----
// ----------------------------------------------------------------------------
// emt_front
// request queue: takes commands and hands them to the executing back end
// ----------------------------------------------------------------------------
module emt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  emt_pkg::cmd_type push_data,
   output logic             full,
   output logic             not_empty,
   output emt_pkg::cmd_type head,
   input  logic             pop
);
   import emt_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);

   cmd_type            slot_ff [QueueDepth];
   logic [PtrW-1:0]    rd_ff, rd_in, wr_ff, wr_in;
   logic [PtrW:0]      cnt_ff, cnt_in;

   always_comb begin
      rd_in  = rd_ff;
      wr_in  = wr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign full      = (cnt_ff == (PtrW+1)'(QueueDepth));
   assign not_empty = (cnt_ff != '0);
   assign head      = slot_ff[rd_ff];
endmodule

// ----- src/emt_back.sv -----
// ----------------------------------------------------------------------------
// emt_back
// table memories and the sequencer that builds and emits triangles
// ----------------------------------------------------------------------------
module emt_back (
   input  logic               clock,
   input  logic               reset,
   input  emt_pkg::csr_type   csr,
   input  logic               cmd_valid,
   input  emt_pkg::cmd_type   cmd,
   output logic               cmd_pop,
   output logic               rsp_valid,
   output logic signed [22:0] rsp_ax,
   output logic signed [22:0] rsp_ay,
   output logic signed [22:0] rsp_az,
   output logic signed [22:0] rsp_bx,
   output logic signed [22:0] rsp_by_coord,
   output logic signed [22:0] rsp_bz,
   output logic signed [22:0] rsp_cx,
   output logic signed [22:0] rsp_cy,
   output logic signed [22:0] rsp_cz,
   output logic               rsp_right_side,
   output logic               rsp_last
);
   import emt_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EDGE  = 4'd1;
   localparam logic [3:0] S_SURF  = 4'd2;
   localparam logic [3:0] S_FEDGE = 4'd3;
   localparam logic [3:0] S_CHECK = 4'd4;
   localparam logic [3:0] S_VERT  = 4'd5;
   localparam logic [3:0] S_DIFF  = 4'd6;
   localparam logic [3:0] S_MUL   = 4'd7;
   localparam logic [3:0] S_CROSS = 4'd8;
   localparam logic [3:0] S_SQ    = 4'd9;
   localparam logic [3:0] S_SUM   = 4'd10;
   localparam logic [3:0] S_SCALE = 4'd11;
   localparam logic [3:0] S_SAT   = 4'd12;
   localparam logic [3:0] S_NEXT  = 4'd13;

   localparam logic signed [33:0] OutLimit = 34'sd3276800;

   logic [23:0] vx_mem [MaxVertices];
   logic [23:0] vy_mem [MaxVertices];
   logic [23:0] vz_mem [MaxVertices];
   logic [63:0] e_mem  [MaxEdges];
   logic [15:0] s_mem  [MaxSurfaces];

   logic [3:0]  state_ff, state_in;
   logic [EaW-1:0] e_addr;
   logic [63:0] e_rd_ff;
   logic [SaW-1:0] s_addr;
   logic [15:0] s_rd_ff;
   logic [VaW-1:0] v_addr;
   logic [23:0] vx_rd_ff, vy_rd_ff, vz_rd_ff;

   logic [15:0] s0_ff, s1_ff, sl_ff, sr_ff, p2_ff;
   logic        side_ff;
   logic [1:0]  vcnt_ff;
   logic signed [23:0] pc_ff [3][3];   // vertex, axis
   logic signed [24:0] d_ff [2][3];
   logic signed [49:0] pr_ff [6];
   logic signed [50:0] cr_ff [3];
   logic [50:0] cr_mag [3];
   logic [47:0] sq_ff [3];
   logic        big_ff;
   logic signed [33:0] prod_ff [9];
   logic signed [22:0] out_ff [9];
   logic        keep_ff;

   logic [13:0] nv, ne, ns;
   logic        proc_start;
   logic [15:0] surf_sel;

   assign nv = (csr.vertex_total > 13'(MaxVertices)) ? 14'(MaxVertices)
                                                     : 14'(csr.vertex_total);
   assign ne = (csr.edge_total > 14'(MaxEdges)) ? 14'(MaxEdges) : csr.edge_total;
   assign ns = (csr.surface_total > 13'(MaxSurfaces)) ? 14'(MaxSurfaces)
                                                      : 14'(csr.surface_total);

   assign cmd_pop    = (state_ff == S_IDLE) && cmd_valid;
   assign proc_start = cmd_pop && (cmd.command == CMD_PROCESS) && nv != '0 &&
                       ne != '0 && ns != '0 && {1'b0, cmd.index} < ne;
   assign surf_sel   = side_ff ? sr_ff : sl_ff;

   // memory writes from load commands
   always_ff @(posedge clock) begin
      if (cmd_pop && cmd.command == CMD_LOAD_VERTEX && {3'b0, cmd.index} < 16'(MaxVertices)) begin
         vx_mem[cmd.index[VaW-1:0]] <= cmd.coord_x;
         vy_mem[cmd.index[VaW-1:0]] <= cmd.coord_y;
         vz_mem[cmd.index[VaW-1:0]] <= cmd.coord_z;
      end
      if (cmd_pop && cmd.command == CMD_LOAD_EDGE && {3'b0, cmd.index} < 16'(MaxEdges)) begin
         e_mem[cmd.index[EaW-1:0]] <= {cmd.right_surface, cmd.left_surface,
                                       cmd.end_vertex, cmd.start_vertex};
      end
      if (cmd_pop && cmd.command == CMD_LOAD_SURFACE &&
          {3'b0, cmd.index} < 16'(MaxSurfaces)) begin
         s_mem[cmd.index[SaW-1:0]] <= cmd.first_edge;
      end
   end

   // registered reads
   always_comb begin
      e_addr = (state_ff == S_IDLE) ? cmd.index[EaW-1:0] : s_rd_ff[EaW-1:0];
      s_addr = surf_sel[SaW-1:0];
      unique case (vcnt_ff)
         2'd0:    v_addr = s0_ff[VaW-1:0];
         2'd1:    v_addr = s1_ff[VaW-1:0];
         default: v_addr = p2_ff[VaW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      e_rd_ff  <= e_mem[e_addr];
      s_rd_ff  <= s_mem[s_addr];
      vx_rd_ff <= vx_mem[v_addr];
      vy_rd_ff <= vy_mem[v_addr];
      vz_rd_ff <= vz_mem[v_addr];
   end

   logic        ok_w;
   logic [15:0] fe_p2;
   logic        side_ok;
   assign ok_w    = surf_sel < {2'b0, ns} && s_rd_ff < {2'b0, ne};
   assign fe_p2   = e_rd_ff[15:0];
   assign side_ok = fe_p2 < {2'b0, nv} && fe_p2 != s0_ff && fe_p2 != s1_ff &&
                    s0_ff < {2'b0, nv} && s1_ff < {2'b0, nv};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cr_mag[k] = cr_ff[k][50] ? 51'(-cr_ff[k]) : 51'(cr_ff[k]);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (proc_start) state_in = S_EDGE;
         S_EDGE:  state_in = S_SURF;
         S_SURF:  state_in = S_FEDGE;    // surface read issued
         S_FEDGE: state_in = ok_w ? S_CHECK : S_NEXT;
         S_CHECK: state_in = side_ok ? S_VERT : S_NEXT;   // first edge read lands
         S_VERT:  state_in = (vcnt_ff == 2'd3) ? S_DIFF : S_VERT;
         S_DIFF:  state_in = S_MUL;
         S_MUL:   state_in = S_CROSS;
         S_CROSS: state_in = S_SQ;
         S_SQ:    state_in = S_SUM;
         S_SUM:   state_in = S_SCALE;
         S_SCALE: state_in = S_SAT;
         S_SAT:   state_in = S_NEXT;
         S_NEXT:  state_in = side_ff ? S_IDLE : S_SURF;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         side_ff    <= 1'b0;
         vcnt_ff    <= '0;
         keep_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         unique case (state_ff)
            S_IDLE: begin
               side_ff    <= 1'b0;
            end
            S_EDGE: begin
               s0_ff <= e_rd_ff[15:0];
               s1_ff <= e_rd_ff[31:16];
               sl_ff <= e_rd_ff[47:32];
               sr_ff <= e_rd_ff[63:48];
               keep_ff <= 1'b0;
            end
            S_FEDGE: keep_ff <= 1'b0;
            S_CHECK: begin
               p2_ff   <= fe_p2;
               vcnt_ff <= 2'd0;
            end
            S_VERT: begin
               // read issued at count k lands in the next cycle, at count k+1
               if (vcnt_ff != 2'd0) begin
                  pc_ff[vcnt_ff-1'b1][0] <= vx_rd_ff;
                  pc_ff[vcnt_ff-1'b1][1] <= vy_rd_ff;
                  pc_ff[vcnt_ff-1'b1][2] <= vz_rd_ff;
               end
               if (vcnt_ff != 2'd3) vcnt_ff <= vcnt_ff + 1'b1;
            end
            S_DIFF: begin
               for (int k = 0; k < 3; k++) begin
                  d_ff[0][k] <= 25'(pc_ff[1][k]) - 25'(pc_ff[0][k]);
                  d_ff[1][k] <= 25'(pc_ff[2][k]) - 25'(pc_ff[0][k]);
               end
               vcnt_ff <= 2'd0;
            end
            S_MUL: begin
               pr_ff[0] <= d_ff[0][1] * d_ff[1][2];
               pr_ff[1] <= d_ff[0][2] * d_ff[1][1];
               pr_ff[2] <= d_ff[0][2] * d_ff[1][0];
               pr_ff[3] <= d_ff[0][0] * d_ff[1][2];
               pr_ff[4] <= d_ff[0][0] * d_ff[1][1];
               pr_ff[5] <= d_ff[0][1] * d_ff[1][0];
            end
            S_CROSS: begin
               cr_ff[0] <= 51'(pr_ff[0]) - 51'(pr_ff[1]);
               cr_ff[1] <= 51'(pr_ff[2]) - 51'(pr_ff[3]);
               cr_ff[2] <= 51'(pr_ff[4]) - 51'(pr_ff[5]);
            end
            S_SQ: begin
               big_ff <= (cr_mag[0] >= 51'd16777216) || (cr_mag[1] >= 51'd16777216) ||
                         (cr_mag[2] >= 51'd16777216);
               for (int k = 0; k < 3; k++) begin
                  sq_ff[k] <= 48'(cr_mag[k][23:0]) * 48'(cr_mag[k][23:0]);
               end
            end
            S_SUM: begin
               // three squares below 2^48 each: watch the carry
               keep_ff <= big_ff ||
                  ({2'b0, sq_ff[0]} + {2'b0, sq_ff[1]} + {2'b0, sq_ff[2]} >=
                   {2'b0, csr.min_area_sq});
            end
            S_SCALE: begin
               for (int v = 0; v < 3; v++) begin
                  for (int k = 0; k < 3; k++) begin
                     prod_ff[3*v+k] <= 34'(pc_ff[v][k]) * $signed({24'b0, csr.scale});
                  end
               end
            end
            S_SAT: begin
               for (int k = 0; k < 9; k++) begin
                  logic signed [33:0] q;
                  q = prod_ff[k][33] ? -34'((-prod_ff[k]) >>> 8) : (prod_ff[k] >>> 8);
                  if (q > OutLimit)       out_ff[k] <= 23'(OutLimit);
                  else if (q < -OutLimit) out_ff[k] <= 23'(-OutLimit);
                  else                    out_ff[k] <= 23'(q);
               end
            end
            S_NEXT: begin
               side_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // the left triangle may be last only if the right side yields nothing, so it
   // waits in the hold registers until the right side is decided
   logic        pend_ff;
   logic signed [22:0] hold_ff [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (state_ff == S_NEXT && !side_ff) begin
         pend_ff <= keep_ff;
         hold_ff <= out_ff;
      end else if (state_ff == S_NEXT && side_ff) begin
         pend_ff <= 1'b0;
      end
   end

   logic        fire;
   assign fire = state_ff == S_NEXT && (side_ff ? (keep_ff || pend_ff) : 1'b0);

   // output stage: a single triangle is sent alone, two go back to back
   logic        q2_ff;
   logic signed [22:0] q2_data_ff [9];
   logic signed [22:0] o_ff [9];
   logic        o_side_ff, o_last_ff, o_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
         q2_ff  <= 1'b0;
      end else if (fire) begin
         o_v_ff <= 1'b1;
         if (pend_ff) begin
            o_ff       <= hold_ff;
            o_side_ff  <= 1'b0;
            o_last_ff  <= !keep_ff;
            q2_ff      <= keep_ff;
            q2_data_ff <= out_ff;
         end else begin
            o_ff      <= out_ff;
            o_side_ff <= 1'b1;
            o_last_ff <= 1'b1;
            q2_ff     <= 1'b0;
         end
      end else if (q2_ff) begin
         o_v_ff    <= 1'b1;
         o_ff      <= q2_data_ff;
         o_side_ff <= 1'b1;
         o_last_ff <= 1'b1;
         q2_ff     <= 1'b0;
      end else begin
         o_v_ff <= 1'b0;
      end
   end

   assign rsp_valid = o_v_ff;
   assign rsp_ax = o_ff[0];
   assign rsp_ay = o_ff[1];
   assign rsp_az = o_ff[2];
   assign rsp_bx = o_ff[3];
   assign rsp_by_coord = o_ff[4];
   assign rsp_bz = o_ff[5];
   assign rsp_cx = o_ff[6];
   assign rsp_cy = o_ff[7];
   assign rsp_cz = o_ff[8];
   assign rsp_right_side = o_side_ff;
   assign rsp_last = o_last_ff;
endmodule

// ----- src/edge_mesh_to_triangles.sv -----
// ----------------------------------------------------------------------------
// edge_mesh_to_triangles
// Requests enter a two-entry queue; busy is high only while that queue is
// full. The back end handles a load request in its idle state. A process
// request holds it for the edge lookup and then, per side, for the surface
// and first edge reads, three vertex reads through one port, cross product,
// squaring, threshold and scaling; a side can be skipped early. Up to two
// triangles follow on rsp_valid, one cycle each and back to back, which the
// receiver must take as they come.
// ----------------------------------------------------------------------------
module edge_mesh_to_triangles (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_data,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic [12:0]        req_index,
   input  logic signed [23:0] req_coord_x,
   input  logic signed [23:0] req_coord_y,
   input  logic signed [23:0] req_coord_z,
   input  logic [15:0]        req_start_vertex,
   input  logic [15:0]        req_end_vertex,
   input  logic [15:0]        req_left_surface,
   input  logic [15:0]        req_right_surface,
   input  logic [15:0]        req_first_edge,
   output logic               rsp_valid,
   output logic signed [22:0] rsp_ax,
   output logic signed [22:0] rsp_ay,
   output logic signed [22:0] rsp_az,
   output logic signed [22:0] rsp_bx,
   output logic signed [22:0] rsp_by_coord,
   output logic signed [22:0] rsp_bz,
   output logic signed [22:0] rsp_cx,
   output logic signed [22:0] rsp_cy,
   output logic signed [22:0] rsp_cz,
   output logic               rsp_right_side,
   output logic               rsp_last
);
   import emt_pkg::*;

   csr_type csr_ff;
   cmd_type req, head;
   logic    full, not_empty, pop, back_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.vertex_total  <= '0;
         csr_ff.edge_total    <= '0;
         csr_ff.surface_total <= '0;
         csr_ff.scale         <= 10'd100;
         csr_ff.min_area_sq   <= 48'd42949673;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_VERTEX_TOTAL:  csr_ff.vertex_total  <= csr_data[12:0];
            CSR_EDGE_TOTAL:    csr_ff.edge_total    <= csr_data[13:0];
            CSR_SURFACE_TOTAL: csr_ff.surface_total <= csr_data[12:0];
            CSR_SCALE:         csr_ff.scale         <= csr_data[9:0];
            CSR_MIN_AREA:      csr_ff.min_area_sq   <= csr_data;
            default: ;
         endcase
      end
   end

   assign req = '{command: req_command, index: req_index, coord_x: req_coord_x,
                  coord_y: req_coord_y, coord_z: req_coord_z,
                  start_vertex: req_start_vertex, end_vertex: req_end_vertex,
                  left_surface: req_left_surface, right_surface: req_right_surface,
                  first_edge: req_first_edge};
   assign busy = full;

   emt_front u_front (
      .clock(clock), .reset(reset), .push(start && !busy), .push_data(req),
      .full(full), .not_empty(not_empty), .head(head), .pop(pop)
   );

   emt_back u_back (
      .clock(clock), .reset(reset), .csr(csr_ff), .cmd_valid(not_empty),
      .cmd(head), .cmd_pop(pop), .rsp_valid(back_valid),
      .rsp_ax(rsp_ax), .rsp_ay(rsp_ay), .rsp_az(rsp_az), .rsp_bx(rsp_bx),
      .rsp_by_coord(rsp_by_coord), .rsp_bz(rsp_bz), .rsp_cx(rsp_cx),
      .rsp_cy(rsp_cy), .rsp_cz(rsp_cz), .rsp_right_side(rsp_right_side),
      .rsp_last(rsp_last)
   );

   assign rsp_valid = back_valid;
endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for edge_mesh_to_triangles. Loads the vertex, edge and
// surface tables, processes edges under several register settings and checks
// each triangle against a predictor of the lookup, area test and scaling.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import emt_pkg::*;

   typedef struct packed {
      logic [8:0][22:0] pos;
      logic             right_side;
      logic             last_tri;
   } triangle_t;

   class triangle_predictor;
      logic [23:0] vx[MaxVertices], vy[MaxVertices], vz[MaxVertices];
      bit          vert_set[MaxVertices];
      logic [15:0] e_s0[MaxEdges], e_s1[MaxEdges], e_left[MaxEdges], e_right[MaxEdges];
      bit          edge_set[MaxEdges];
      logic [15:0] surf_edge[MaxSurfaces];
      bit          surf_set[MaxSurfaces];
      int unsigned n_vert, n_edge, n_surf, scale_r;
      longint unsigned min_area;
      triangle_t   pending[$];
      int          failures;

      function new();
         n_vert = 0;
         n_edge = 0;
         n_surf = 0;
         scale_r = 100;
         min_area = 42949673;
         failures = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [47:0] d);
         case (idx)
            CSR_VERTEX_TOTAL:  n_vert = d[12:0];
            CSR_EDGE_TOTAL:    n_edge = d[13:0];
            CSR_SURFACE_TOTAL: n_surf = d[12:0];
            CSR_SCALE:         scale_r = d[9:0];
            CSR_MIN_AREA:      min_area = d;
            default: ;
         endcase
      endfunction

      function int unsigned clip(int unsigned c, int unsigned depth);
         return c > depth ? depth : c;
      endfunction

      function longint sx(logic [23:0] v);
         return longint'($signed(v));
      endfunction

      function logic [22:0] scaled(logic [23:0] raw);
         longint p, q;
         p = sx(raw) * longint'(scale_r);
         q = p / 256;
         if (q > 3276800) q = 3276800;
         if (q < -3276800) q = -3276800;
         return q[22:0];
      endfunction

      function bit large_enough(int unsigned p0, int unsigned p1, int unsigned p2);
         longint ax, ay, az, bx, by, bz;
         longint c[3];
         longint unsigned m, sum;
         ax = sx(vx[p1]) - sx(vx[p0]);
         ay = sx(vy[p1]) - sx(vy[p0]);
         az = sx(vz[p1]) - sx(vz[p0]);
         bx = sx(vx[p2]) - sx(vx[p0]);
         by = sx(vy[p2]) - sx(vy[p0]);
         bz = sx(vz[p2]) - sx(vz[p0]);
         c[0] = ay * bz - az * by;
         c[1] = az * bx - ax * bz;
         c[2] = ax * by - ay * bx;
         sum = 0;
         for (int k = 0; k < 3; k++) begin
            m = c[k] < 0 ? -c[k] : c[k];
            // one square alone is above any 48-bit threshold
            if (m >= 64'd16777216) return 1;
            sum += m * m;
         end
         return sum >= min_area;
      endfunction

      // walks one process request; returns 1 if it would touch an unwritten
      // entry, and queues the triangles when asked to
      function bit trace_edge(int unsigned idx, bit queue_it);
         int unsigned nv, ne, ns, s0, s1, sf, fe, p2, n;
         triangle_t t;
         nv = clip(n_vert, MaxVertices);
         ne = clip(n_edge, MaxEdges);
         ns = clip(n_surf, MaxSurfaces);
         n = 0;
         if (nv == 0 || ne == 0 || ns == 0 || idx >= ne) return 0;
         if (!edge_set[idx]) return 1;
         s0 = e_s0[idx];
         s1 = e_s1[idx];
         for (int j = 0; j < 2; j++) begin
            sf = j ? e_right[idx] : e_left[idx];
            if (sf >= ns) continue;
            if (!surf_set[sf]) return 1;
            fe = surf_edge[sf];
            if (fe >= ne) continue;
            if (!edge_set[fe]) return 1;
            p2 = e_s0[fe];
            if (p2 >= nv) continue;
            if (!vert_set[p2]) return 1;
            if (s0 == p2 || s1 == p2) continue;
            if (s0 >= nv || s1 >= nv) continue;
            if (!vert_set[s0] || !vert_set[s1]) return 1;
            if (!queue_it || !large_enough(s0, s1, p2)) continue;
            t.pos[0] = scaled(vx[s0]);
            t.pos[1] = scaled(vy[s0]);
            t.pos[2] = scaled(vz[s0]);
            t.pos[3] = scaled(vx[s1]);
            t.pos[4] = scaled(vy[s1]);
            t.pos[5] = scaled(vz[s1]);
            t.pos[6] = scaled(vx[p2]);
            t.pos[7] = scaled(vy[p2]);
            t.pos[8] = scaled(vz[p2]);
            t.right_side = 1'(j);
            t.last_tri = 0;
            pending.insert(pending.size(), t);
            n++;
         end
         if (n > 0) pending[pending.size() - 1].last_tri = 1;
         return 0;
      endfunction

      function void note_request(cmd_type r);
         bit dummy;
         case (r.command)
            CMD_LOAD_VERTEX: if (r.index < MaxVertices) begin
               vx[r.index] = r.coord_x;
               vy[r.index] = r.coord_y;
               vz[r.index] = r.coord_z;
               vert_set[r.index] = 1;
            end
            CMD_LOAD_EDGE: begin
               e_s0[r.index] = r.start_vertex;
               e_s1[r.index] = r.end_vertex;
               e_left[r.index] = r.left_surface;
               e_right[r.index] = r.right_surface;
               edge_set[r.index] = 1;
            end
            CMD_LOAD_SURFACE: if (r.index < MaxSurfaces) begin
               surf_edge[r.index] = r.first_edge;
               surf_set[r.index] = 1;
            end
            default: dummy = trace_edge(r.index, 1);
         endcase
      endfunction

      function void complain(string msg);
         failures++;
         if (failures <= 10) $display("%0t ns: %s", $time, msg);
      endfunction

      function void check_triangle(triangle_t got);
         triangle_t want;
         if (pending.size() == 0) begin
            complain("unexpected triangle");
            return;
         end
         want = pending.pop_front();
         for (int k = 0; k < 9; k++)
            if (got.pos[k] !== want.pos[k])
               complain($sformatf("coordinate %0d: expected %0d got %0d", k,
                  $signed(want.pos[k]), $signed(got.pos[k])));
         if (got.right_side !== want.right_side)
            complain($sformatf("right_side: expected %0b got %0b",
               want.right_side, got.right_side));
         if (got.last_tri !== want.last_tri)
            complain($sformatf("last: expected %0b got %0b", want.last_tri, got.last_tri));
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               csr_write;
   logic [2:0]         csr_index;
   logic [47:0]        csr_data;
   logic               start;
   logic               busy;
   logic [1:0]         req_command;
   logic [12:0]        req_index;
   logic signed [23:0] req_coord_x, req_coord_y, req_coord_z;
   logic [15:0]        req_start_vertex, req_end_vertex;
   logic [15:0]        req_left_surface, req_right_surface, req_first_edge;
   logic               rsp_valid;
   logic signed [22:0] rsp_ax, rsp_ay, rsp_az, rsp_bx, rsp_by_coord, rsp_bz;
   logic signed [22:0] rsp_cx, rsp_cy, rsp_cz;
   logic               rsp_right_side, rsp_last;

   triangle_predictor ledger = new();

   edge_mesh_to_triangles u_top (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .start(start), .busy(busy),
      .req_command(req_command), .req_index(req_index),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .req_start_vertex(req_start_vertex), .req_end_vertex(req_end_vertex),
      .req_left_surface(req_left_surface), .req_right_surface(req_right_surface),
      .req_first_edge(req_first_edge),
      .rsp_valid(rsp_valid),
      .rsp_ax(rsp_ax), .rsp_ay(rsp_ay), .rsp_az(rsp_az),
      .rsp_bx(rsp_bx), .rsp_by_coord(rsp_by_coord), .rsp_bz(rsp_bz),
      .rsp_cx(rsp_cx), .rsp_cy(rsp_cy), .rsp_cz(rsp_cz),
      .rsp_right_side(rsp_right_side), .rsp_last(rsp_last)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin : watch
      triangle_t got;
      if (!reset && rsp_valid) begin
         got.pos[0] = rsp_ax;
         got.pos[1] = rsp_ay;
         got.pos[2] = rsp_az;
         got.pos[3] = rsp_bx;
         got.pos[4] = rsp_by_coord;
         got.pos[5] = rsp_bz;
         got.pos[6] = rsp_cx;
         got.pos[7] = rsp_cy;
         got.pos[8] = rsp_cz;
         got.right_side = rsp_right_side;
         got.last_tri = rsp_last;
         ledger.check_triangle(got);
      end
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   // mostly back to back, sometimes short, now and then long
   function int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function cmd_type noise_fields();
      cmd_type r;
      r.command = 2'($urandom);
      r.index = 13'($urandom);
      r.coord_x = 24'($urandom);
      r.coord_y = 24'($urandom);
      r.coord_z = 24'($urandom);
      r.start_vertex = 16'($urandom);
      r.end_vertex = 16'($urandom);
      r.left_surface = 16'($urandom);
      r.right_surface = 16'($urandom);
      r.first_edge = 16'($urandom);
      return r;
   endfunction

   function logic [23:0] rand_coord();
      int k;
      k = $urandom_range(0, 99);
      if (k < 70) return 24'($urandom_range(0, 4000) - 2000);
      if (k < 75) return 24'h7FFFFF;
      if (k < 80) return 24'h800000;
      return 24'($urandom);
   endfunction

   // slot of a load: mostly inside the working span
   function int unsigned pick_slot(int unsigned span);
      return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, span - 1);
   endfunction

   // a table reference: mostly valid, sometimes exactly the count, sometimes anything
   function int unsigned pick_ref(int unsigned span, int unsigned count);
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return count & 16'hFFFF;
      if (k == 1) return $urandom_range(0, 65535);
      return $urandom_range(0, span - 1);
   endfunction

   task issue_request(cmd_type r);
      int n;
      start <= 1'b1;
      req_command <= r.command;
      req_index <= r.index;
      req_coord_x <= r.coord_x;
      req_coord_y <= r.coord_y;
      req_coord_z <= r.coord_z;
      req_start_vertex <= r.start_vertex;
      req_end_vertex <= r.end_vertex;
      req_left_surface <= r.left_surface;
      req_right_surface <= r.right_surface;
      req_first_edge <= r.first_edge;
      @(posedge clock);
      while (busy) @(posedge clock);
      ledger.note_request(r);
      n = gap_len();
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task load_vertex(int unsigned i, logic [23:0] x, logic [23:0] y, logic [23:0] z);
      cmd_type r;
      r = noise_fields();
      r.command = CMD_LOAD_VERTEX;
      r.index = 13'(i);
      r.coord_x = x;
      r.coord_y = y;
      r.coord_z = z;
      issue_request(r);
   endtask

   task load_edge(int unsigned i, int unsigned s0, int unsigned s1, int unsigned l,
                  int unsigned rt);
      cmd_type r;
      r = noise_fields();
      r.command = CMD_LOAD_EDGE;
      r.index = 13'(i);
      r.start_vertex = 16'(s0);
      r.end_vertex = 16'(s1);
      r.left_surface = 16'(l);
      r.right_surface = 16'(rt);
      issue_request(r);
   endtask

   task load_surface(int unsigned i, int unsigned fe);
      cmd_type r;
      r = noise_fields();
      r.command = CMD_LOAD_SURFACE;
      r.index = 13'(i);
      r.first_edge = 16'(fe);
      issue_request(r);
   endtask

   task process_edge(int unsigned i);
      cmd_type r;
      r = noise_fields();
      r.command = CMD_PROCESS;
      r.index = 13'(i);
      issue_request(r);
   endtask

   task write_reg(logic [2:0] idx, logic [47:0] d);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      ledger.set_reg(idx, d);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task settle();
      start <= 1'b0;
      while (ledger.pending.size() != 0) @(posedge clock);
   endtask

   // requests that give no triangle may still be in flight
   task drain();
      settle();
      repeat (150) @(posedge clock);
   endtask

   initial begin
      int unsigned cv, ce, cs, sv, se, ss, idx, sent;
      logic [9:0]  scl;
      logic [47:0] area;
      int k;

      reset <= 1'b1;
      csr_write <= 1'b0;
      csr_index <= CSR_VERTEX_TOTAL;
      csr_data <= '0;
      start <= 1'b0;
      req_command <= CMD_LOAD_VERTEX;
      req_index <= '0;
      req_coord_x <= '0;
      req_coord_y <= '0;
      req_coord_z <= '0;
      req_start_vertex <= '0;
      req_end_vertex <= '0;
      req_left_surface <= '0;
      req_right_surface <= '0;
      req_first_edge <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // counts still zero: processing gives nothing; loads past the table are dropped
      process_edge(0);
      load_vertex(4096, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      load_surface(8191, 16'hFFFF);
      drain();
      write_reg(CSR_VERTEX_TOTAL, 8);
      write_reg(CSR_EDGE_TOTAL, 8);
      write_reg(CSR_SURFACE_TOTAL, 4);
      write_reg(CSR_SCALE, 1000);

      load_vertex(0, 0, 0, 0);
      load_vertex(1, 24'h7FFFFF, 0, 0);
      load_vertex(2, 0, 24'h800000, 0);
      load_vertex(3, 256, 256, 256);
      load_vertex(4, 512, 512, 512);       // collinear with vertices 0 and 3
      load_vertex(5, -256, 300, 7);
      load_vertex(6, -1, -255, -257);
      load_vertex(7, 1000, -77, 0);
      load_edge(0, 0, 1, 0, 1);            // both sides kept
      load_edge(1, 0, 3, 2, 9);            // third vertex out of range, right surface out
      load_edge(2, 0, 9, 0, 0);            // end vertex out of range
      load_edge(3, 2, 4, 0, 3);            // third vertex shared, first edge out of range
      load_edge(4, 2, 5, 3, 2);
      load_edge(5, 3, 1, 1, 0);
      load_edge(6, 12, 0, 1, 1);           // start vertex out of range
      load_edge(7, 4, 0, 1, 0);            // left side degenerate
      load_surface(0, 4);
      load_surface(1, 5);
      load_surface(2, 6);
      load_surface(3, 100);
      for (int i = 0; i <= 8; i++) process_edge(i);
      drain();
      write_reg(CSR_MIN_AREA, 48'hFFFF_FFFF_FFFF);
      process_edge(0);
      process_edge(5);
      drain();

      for (int p = 0; p < 10; p++) begin
         cv = (p == 1) ? 8191 : (p == 2) ? 4096 : $urandom_range(4, 64);
         ce = (p == 1) ? 16383 : (p == 2) ? 8192 : $urandom_range(4, 64);
         cs = (p == 1) ? 8191 : (p == 2) ? 4096 : $urandom_range(2, 40);
         scl = (p == 0) ? 10'd1 : (p == 1) ? 10'd1000 : (p == 3) ? 10'd1023 :
               (p == 4) ? 10'd0 : 10'($urandom_range(1, 1000));
         k = $urandom_range(0, 2);
         area = (p == 0) ? 48'd0 : (p == 1) ? 48'hFFFF_FFFF_FFFF :
                (p == 2) ? 48'd42949673 : 48'({$urandom, $urandom} >> $urandom_range(8, 40));
         write_reg(CSR_VERTEX_TOTAL, cv);
         write_reg(CSR_EDGE_TOTAL, ce);
         write_reg(CSR_SURFACE_TOTAL, cs);
         write_reg(CSR_SCALE, scl);
         write_reg(CSR_MIN_AREA, area);
         sv = ledger.clip(cv, MaxVertices);
         se = ledger.clip(ce, MaxEdges);
         ss = ledger.clip(cs, MaxSurfaces);
         if (sv > 32) sv = 32;
         if (se > 32) se = 32;
         if (ss > 16) ss = 16;

         // fill the working span so that most edges lead somewhere
         for (int i = 0; i < sv; i++) load_vertex(i, rand_coord(), rand_coord(), rand_coord());
         for (int i = 0; i < se; i++)
            load_edge(i, pick_ref(sv, cv), pick_ref(sv, cv), pick_ref(ss, cs),
                      pick_ref(ss, cs));
         for (int i = 0; i < ss; i++) load_surface(i, pick_ref(se, ce));

         sent = 0;
         while (sent < 55) begin
            k = $urandom_range(0, 99);
            if (p == 0 && sent == 30) settle();
            if (k < 50) begin
               idx = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 8191) :
                     $urandom_range(0, se - 1);
               if (ledger.trace_edge(idx, 0)) continue;
               process_edge(idx);
            end else if (k < 65) begin
               load_vertex(pick_slot(sv), rand_coord(), rand_coord(), rand_coord());
            end else if (k < 85) begin
               load_edge(pick_slot(se), pick_ref(sv, cv), pick_ref(sv, cv),
                         pick_ref(ss, cs), pick_ref(ss, cs));
            end else begin
               load_surface(pick_slot(ss), pick_ref(se, ce));
            end
            sent++;
         end
         drain();
      end

      if (ledger.failures == 0 && ledger.pending.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
